FILE: src/spi_slave_waveform_frame_sender_top_defines.svh
// ----------------------------------------------------------------------------
// spi_slave_waveform_frame_sender_top_defines.svh
// Assertion macros for the frame sender top module.
// ----------------------------------------------------------------------------
`ifndef SPI_SLAVE_WAVEFORM_FRAME_SENDER_TOP_DEFINES_SVH
`define SPI_SLAVE_WAVEFORM_FRAME_SENDER_TOP_DEFINES_SVH

// generic concurrent check on an explicit clock and active-low reset
`define SWFS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same check on the block clock and reset
`define SWFS_ASSERT(lbl, prop, msg) \
    `SWFS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: src/swfs_pkg.sv
// ----------------------------------------------------------------------------
// swfs_pkg
// Types, constants and helpers for the SPI waveform frame sender.
// ----------------------------------------------------------------------------
package swfs_pkg;

    // default sample store depth
    localparam int BUFFER_DEPTH_DEF = 512;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BYTES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM_INFO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_CODES = 3'd6;

    // frame marker lengths (last index of each run; LOW_BYTES is a byte count)
    localparam logic [3:0] START_LAST  = 4'd8;
    localparam logic [3:0] FINISH_LAST = 4'd9;
    localparam logic [3:0] LOW_BYTES   = 4'd8;
    localparam logic [3:0] WORD_LAST   = 4'd3;

    // input op codes
    localparam logic OP_SPI_BYTE = 1'b0;
    localparam logic OP_SAMPLE   = 1'b1;

    // frame phase; code 7 is unused and treated as finish
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SENSOR  = 3'd1,
        PH_CS      = 3'd2,
        PH_FREQ    = 3'd3,
        PH_TIME    = 3'd4,
        PH_SAMPLES = 3'd5,
        PH_FINISH  = 3'd6
    } t_phase;

    // where the result byte comes from
    typedef enum logic [1:0] {
        SRC_DIRECT = 2'd0,
        SRC_HIGH   = 2'd1,
        SRC_LOW    = 2'd2
    } t_src;

    // byte k of a 64-bit word
    function automatic logic [7:0] byte_of(logic [63:0] word, logic [2:0] k);
        return word[{k, 3'b000} +: 8];
    endfunction

endpackage

FILE: src/swfs_ram.sv
// ----------------------------------------------------------------------------
// swfs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/spi_slave_waveform_frame_sender_top.sv
// Path: a result byte is captured in stage 1 at the accepting edge and then moves into
//   the output register, which drives the output valid and byte.
// Throughput: one input request per cycle while stage 1 is free or advancing; the store read
//   (one port, registered read) is the only memory access on the frame path.
// Reset: synchronous, active low; clears mode, frame counters, pipeline and the
//   configuration registers. Sample store contents are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// spi_slave_waveform_frame_sender_top
// SPI slave responder: decodes commands, streams a waveform frame built from
// configuration bytes and the sample store.
// ----------------------------------------------------------------------------
`include "spi_slave_waveform_frame_sender_top_defines.svh"

module spi_slave_waveform_frame_sender_top #(
    parameter int BUFFER_DEPTH = swfs_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [7:0]                    i_rx_byte,
    input  logic [9:0]                    i_fill_level,
    input  logic [8:0]                    i_sample_index,
    input  logic [swfs_pkg::SAMPLE_W-1:0] i_sample_value,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_tx_byte,
    output logic                          o_frame_end,
    // configuration port
    input  logic                          i_cfg_we,
    input  logic [swfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swfs_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int PW = $clog2(BUFFER_DEPTH + 1);

    // configuration registers
    logic [15:0] r_id_bytes;
    logic [63:0] r_waveform_info;
    logic [63:0] r_start_low;
    logic [7:0]  r_start_high;
    logic [63:0] r_finish_low;
    logic [15:0] r_finish_high;
    logic [39:0] r_protocol_codes;

    // frame machine state
    logic             r_tx_mode, n_tx_mode;
    swfs_pkg::t_phase r_phase,   n_phase;
    logic [3:0]       r_mc,      n_mc;
    logic [PW-1:0]    r_ptr,     n_ptr;
    logic             r_low,     n_low;

    // stage 1 (waits on store read) and output register
    logic             r_s1_valid;
    swfs_pkg::t_src   r_s1_src;
    logic [7:0]       r_s1_byte;
    logic             r_s1_end;
    logic             r_o_valid;
    logic [7:0]       r_o_byte;
    logic             r_o_end;

    // result of the accepted request
    logic             res_valid;
    swfs_pkg::t_src   res_src;
    logic [7:0]       res_byte;
    logic             res_end;
    logic             rd_en;

    logic                          in_acc;
    logic                          s1_adv;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic [swfs_pkg::SAMPLE_W-1:0] rd_data;
    logic [7:0]                    s1_out_byte;

    // handshake
    assign s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // sample write port
    assign wr_en   = in_acc && (i_op == swfs_pkg::OP_SAMPLE)
                     && (32'(i_sample_index) < BUFFER_DEPTH);
    assign wr_addr = AW'(32'(i_sample_index));
    assign rd_addr = AW'(32'(r_ptr));

    swfs_ram #(
        .WIDTH (swfs_pkg::SAMPLE_W),
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_sample_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // command decode and frame sequencing
    always_comb begin
        n_tx_mode = r_tx_mode;
        n_phase   = r_phase;
        n_mc      = r_mc;
        n_ptr     = r_ptr;
        n_low     = r_low;
        res_valid = 1'b0;
        res_src   = swfs_pkg::SRC_DIRECT;
        res_byte  = 8'h00;
        res_end   = 1'b0;
        rd_en     = 1'b0;
        if (in_acc && (i_op == swfs_pkg::OP_SPI_BYTE)) begin
            if (!r_tx_mode) begin
                // command mode
                if (i_rx_byte == r_protocol_codes[7:0]) begin
                    res_valid = 1'b1;
                    res_byte  = (32'(i_fill_level) < BUFFER_DEPTH) ?
                                r_protocol_codes[23:16] : r_protocol_codes[31:24];
                end else if (i_rx_byte == r_protocol_codes[15:8]) begin
                    n_tx_mode = 1'b1;
                    n_phase   = swfs_pkg::PH_START;
                    n_mc      = '0;
                    n_ptr     = '0;
                    n_low     = 1'b0;
                end else begin
                    res_valid = 1'b1;
                    res_byte  = r_protocol_codes[39:32];
                end
            end else begin
                unique case (r_phase)
                    swfs_pkg::PH_START: begin
                        res_valid = 1'b1;
                        res_byte  = (r_mc < swfs_pkg::LOW_BYTES) ?
                                    swfs_pkg::byte_of(r_start_low, r_mc[2:0]) : r_start_high;
                        n_mc      = r_mc + 4'd1;
                        if (r_mc >= swfs_pkg::START_LAST) begin
                            n_phase = swfs_pkg::PH_SENSOR;
                            n_mc    = '0;
                        end
                    end
                    swfs_pkg::PH_SENSOR: begin
                        res_valid = 1'b1;
                        res_byte  = r_id_bytes[7:0];
                        n_phase   = swfs_pkg::PH_CS;
                    end
                    swfs_pkg::PH_CS: begin
                        res_valid = 1'b1;
                        res_byte  = r_id_bytes[15:8];
                        n_phase   = swfs_pkg::PH_FREQ;
                        n_mc      = '0;
                    end
                    swfs_pkg::PH_FREQ, swfs_pkg::PH_TIME: begin
                        res_valid = 1'b1;
                        res_byte  = swfs_pkg::byte_of(r_waveform_info,
                                        {r_phase == swfs_pkg::PH_TIME, r_mc[1:0]});
                        n_mc      = r_mc + 4'd1;
                        if (r_mc >= swfs_pkg::WORD_LAST) begin
                            n_phase = (r_phase == swfs_pkg::PH_FREQ) ?
                                      swfs_pkg::PH_TIME : swfs_pkg::PH_SAMPLES;
                            n_mc    = '0;
                        end
                    end
                    swfs_pkg::PH_SAMPLES: begin
                        if (32'(r_ptr) < BUFFER_DEPTH) begin
                            // byte picked in stage 1 from the registered store data
                            res_valid = 1'b1;
                            rd_en     = 1'b1;
                            res_src   = r_low ? swfs_pkg::SRC_LOW : swfs_pkg::SRC_HIGH;
                            n_low     = !r_low;
                            if (r_low) begin
                                n_ptr = r_ptr + PW'(1);
                            end
                        end else begin
                            n_phase = swfs_pkg::PH_FINISH;
                            n_mc    = '0;
                        end
                    end
                    default: begin
                        // finish marker
                        res_valid = 1'b1;
                        if (r_mc < swfs_pkg::LOW_BYTES) begin
                            res_byte = swfs_pkg::byte_of(r_finish_low, r_mc[2:0]);
                        end else if (r_mc == swfs_pkg::LOW_BYTES) begin
                            res_byte = r_finish_high[7:0];
                        end else begin
                            res_byte = r_finish_high[15:8];
                        end
                        n_mc = r_mc + 4'd1;
                        if (r_mc >= swfs_pkg::FINISH_LAST) begin
                            n_tx_mode = 1'b0;
                            n_phase   = swfs_pkg::PH_START;
                            n_mc      = '0;
                            res_end   = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // final byte select once store data is out
    always_comb begin
        unique case (r_s1_src)
            swfs_pkg::SRC_HIGH: s1_out_byte = rd_data[15:8];
            swfs_pkg::SRC_LOW:  s1_out_byte = rd_data[7:0];
            default:            s1_out_byte = r_s1_byte;
        endcase
    end

    // state, config and pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_bytes       <= '0;
            r_waveform_info  <= '0;
            r_start_low      <= '0;
            r_start_high     <= '0;
            r_finish_low     <= '0;
            r_finish_high    <= '0;
            r_protocol_codes <= '0;
            r_tx_mode        <= 1'b0;
            r_phase          <= swfs_pkg::PH_START;
            r_mc             <= '0;
            r_ptr            <= '0;
            r_low            <= 1'b0;
            r_s1_valid       <= 1'b0;
            r_o_valid        <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    swfs_pkg::CFG_ID_BYTES:       r_id_bytes       <= i_cfg_data[15:0];
                    swfs_pkg::CFG_WAVEFORM_INFO:  r_waveform_info  <= i_cfg_data;
                    swfs_pkg::CFG_START_LOW:      r_start_low      <= i_cfg_data;
                    swfs_pkg::CFG_START_HIGH:     r_start_high     <= i_cfg_data[7:0];
                    swfs_pkg::CFG_FINISH_LOW:     r_finish_low     <= i_cfg_data;
                    swfs_pkg::CFG_FINISH_HIGH:    r_finish_high    <= i_cfg_data[15:0];
                    swfs_pkg::CFG_PROTOCOL_CODES: r_protocol_codes <= i_cfg_data[39:0];
                    default: ;
                endcase
            end

            // frame machine
            r_tx_mode <= n_tx_mode;
            r_phase   <= n_phase;
            r_mc      <= n_mc;
            r_ptr     <= n_ptr;
            r_low     <= n_low;

            // stage 1
            if (in_acc && res_valid) begin
                r_s1_valid <= 1'b1;
                r_s1_src   <= res_src;
                r_s1_byte  <= res_byte;
                r_s1_end   <= res_end;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // output register
            if (s1_adv) begin
                r_o_valid <= 1'b1;
                r_o_byte  <= s1_out_byte;
                r_o_end   <= r_s1_end;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_tx_byte   = r_o_byte;
    assign o_frame_end = r_o_end;

    // checks
    `SWFS_ASSERT(a_no_accept_when_full, (r_s1_valid && r_o_valid && !i_out_ready) |-> !o_in_ready, "request accepted with pipeline full")
    `SWFS_ASSERT(a_ptr_in_range, 32'(r_ptr) <= BUFFER_DEPTH, "sample pointer beyond store depth")
    `SWFS_ASSERT(a_start_count, (r_phase == swfs_pkg::PH_START) |-> (r_mc <= swfs_pkg::START_LAST), "start marker count out of range")
    `SWFS_ASSERT(a_end_leaves_tx, (in_acc && res_valid && res_end) |=> (!r_tx_mode && r_s1_valid && r_s1_end), "frame end did not return to command mode")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI waveform frame sender: drives SPI byte and
// sample write requests under random idle and stall, predicts each reply
// byte in step with the block and compares every reply in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH       = swfs_pkg::BUFFER_DEPTH_DEF;
    localparam int LATENCY     = 2;
    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    // byte positions inside the protocol code register
    localparam int CODE_READY_CMD   = 0;
    localparam int CODE_DATA_CMD    = 1;
    localparam int CODE_BUSY        = 2;
    localparam int CODE_READY_REPLY = 3;
    localparam int CODE_DUMMY       = 4;

    typedef struct packed {
        logic        op;
        logic [7:0]  rx;
        logic [9:0]  fill;
        logic [8:0]  idx;
        logic [15:0] val;
    } t_spi_req;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } t_tx_res;

    // DUT connections
    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic                           in_op     = swfs_pkg::OP_SPI_BYTE;
    logic [7:0]                     in_rx     = 8'h00;
    logic [9:0]                     in_fill   = 10'd0;
    logic [8:0]                     in_idx    = 9'd0;
    logic [15:0]                    in_val    = 16'h0000;
    logic                           out_valid;
    logic                           out_ready = 1'b1;
    logic [7:0]                     out_tx;
    logic                           out_end;
    logic                           cfg_we    = 1'b0;
    logic [swfs_pkg::CFG_IDX_W-1:0] cfg_index = swfs_pkg::CFG_ID_BYTES;
    logic [swfs_pkg::CFG_W-1:0]     cfg_data  = '0;

    // predicted configuration
    logic [15:0] ids_m   = '0;
    logic [63:0] wave_m  = '0;
    logic [63:0] slo_m   = '0;
    logic [7:0]  shi_m   = '0;
    logic [63:0] flo_m   = '0;
    logic [15:0] fhi_m   = '0;
    logic [39:0] codes_m = '0;

    // predicted frame state
    bit               xmit_m  = 1'b0;
    swfs_pkg::t_phase phase_m = swfs_pkg::PH_START;
    int               mark_m  = 0;
    int               ptr_m   = 0;
    bit               low_m   = 1'b0;
    logic [15:0]      store_m [DEPTH];

    t_tx_res tx_due[$];
    t_tx_res chk_want;
    int      err_cnt   = 0;
    int      sent_cnt  = 0;
    int      gap_pct   = 0;
    int      stall_pct = 0;
    bit      calm      = 1'b0;

    spi_slave_waveform_frame_sender_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (in_op),
        .i_rx_byte      (in_rx),
        .i_fill_level   (in_fill),
        .i_sample_index (in_idx),
        .i_sample_value (in_val),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_tx_byte      (out_tx),
        .o_frame_end    (out_end),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] lane(input logic [63:0] w, input int k);
        return w[8*k +: 8];
    endfunction

    // idle density for the next stretch; half the stretches have none
    function automatic int idle_pct();
        unique case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return 8;
            default: return 30;
        endcase
    endfunction

    function automatic logic [9:0] pick_fill();
        unique case ($urandom_range(0, 3))
            0: return 10'd511;
            1: return 10'd512;
            default: return 10'($urandom_range(0, 512));
        endcase
    endfunction

    // reply byte for one request; returns 0 when the request gives none
    function automatic bit frame_step(input t_spi_req r, output t_tx_res res);
        logic [7:0]  b;
        logic [15:0] s;
        res = '0;
        b = 8'h00;
        if (r.op == swfs_pkg::OP_SAMPLE) begin
            if (int'(r.idx) < DEPTH) store_m[r.idx] = r.val;
            return 1'b0;
        end
        // command mode
        if (!xmit_m) begin
            if (r.rx == lane(codes_m, CODE_READY_CMD)) begin
                res.tx = (int'(r.fill) < DEPTH) ? lane(codes_m, CODE_BUSY)
                                                : lane(codes_m, CODE_READY_REPLY);
                return 1'b1;
            end
            if (r.rx == lane(codes_m, CODE_DATA_CMD)) begin
                xmit_m  = 1'b1;
                phase_m = swfs_pkg::PH_START;
                mark_m  = 0;
                ptr_m   = 0;
                low_m   = 1'b0;
                return 1'b0;
            end
            res.tx = lane(codes_m, CODE_DUMMY);
            return 1'b1;
        end
        // transmit mode: rx byte is ignored
        unique case (phase_m)
            swfs_pkg::PH_START: begin
                b = (mark_m < 8) ? lane(slo_m, mark_m) : shi_m;
                mark_m++;
                if (mark_m >= 9) begin
                    phase_m = swfs_pkg::PH_SENSOR;
                    mark_m  = 0;
                end
            end
            swfs_pkg::PH_SENSOR: begin
                b = ids_m[7:0];
                phase_m = swfs_pkg::PH_CS;
            end
            swfs_pkg::PH_CS: begin
                b = ids_m[15:8];
                phase_m = swfs_pkg::PH_FREQ;
                mark_m  = 0;
            end
            swfs_pkg::PH_FREQ, swfs_pkg::PH_TIME: begin
                b = lane(wave_m, mark_m + ((phase_m == swfs_pkg::PH_TIME) ? 4 : 0));
                mark_m++;
                if (mark_m >= 4) begin
                    if (phase_m == swfs_pkg::PH_FREQ) phase_m = swfs_pkg::PH_TIME;
                    else phase_m = swfs_pkg::PH_SAMPLES;
                    mark_m = 0;
                end
            end
            swfs_pkg::PH_SAMPLES: begin
                // past the last sample: silent step into the finish marker
                if (ptr_m >= DEPTH) begin
                    phase_m = swfs_pkg::PH_FINISH;
                    mark_m  = 0;
                    return 1'b0;
                end
                s = store_m[ptr_m];
                if (!low_m) begin
                    b = s[15:8];
                    low_m = 1'b1;
                end else begin
                    b = s[7:0];
                    low_m = 1'b0;
                    ptr_m++;
                end
            end
            default: begin
                if (mark_m < 8) b = lane(flo_m, mark_m);
                else if (mark_m == 8) b = fhi_m[7:0];
                else b = fhi_m[15:8];
                mark_m++;
                if (mark_m >= 10) begin
                    xmit_m   = 1'b0;
                    phase_m  = swfs_pkg::PH_START;
                    mark_m   = 0;
                    res.last = 1'b1;
                end
            end
        endcase
        res.tx = b;
        return 1'b1;
    endfunction

    // send one request, with an optional idle burst ahead of it
    task automatic send_req(input t_spi_req r);
        t_tx_res res;
        int      n;
        if (sent_cnt % 64 == 0) gap_pct = idle_pct();
        sent_cnt++;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_op    <= r.op;
        in_rx    <= r.rx;
        in_fill  <= r.fill;
        in_idx   <= r.idx;
        in_val   <= r.val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (frame_step(r, res)) tx_due.push_back(res);
    endtask

    task automatic send_spi(input logic [7:0] rx, input logic [9:0] fill);
        send_req(t_spi_req'{swfs_pkg::OP_SPI_BYTE, rx, fill, 9'($urandom_range(0, 511)),
                            16'($urandom_range(0, 65535))});
    endtask

    task automatic send_sample(input logic [8:0] idx, input logic [15:0] val);
        send_req(t_spi_req'{swfs_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)), pick_fill(),
                            idx, val});
    endtask

    // hold off until every reply is in and silent requests have drained
    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tx_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [swfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        unique case (idx)
            swfs_pkg::CFG_ID_BYTES:       ids_m   = data[15:0];
            swfs_pkg::CFG_WAVEFORM_INFO:  wave_m  = data;
            swfs_pkg::CFG_START_LOW:      slo_m   = data;
            swfs_pkg::CFG_START_HIGH:     shi_m   = data[7:0];
            swfs_pkg::CFG_FINISH_LOW:     flo_m   = data;
            swfs_pkg::CFG_FINISH_HIGH:    fhi_m   = data[15:0];
            swfs_pkg::CFG_PROTOCOL_CODES: codes_m = data[39:0];
            default: ;
        endcase
    endtask

    // write all registers with the block idle
    task automatic load_settings(input logic [15:0] ids, input logic [63:0] wave,
                                 input logic [63:0] slo, input logic [7:0] shi,
                                 input logic [63:0] flo, input logic [15:0] fhi,
                                 input logic [39:0] codes);
        wait_results_done();
        cfg_write(swfs_pkg::CFG_ID_BYTES, {48'h0, ids});
        cfg_write(swfs_pkg::CFG_WAVEFORM_INFO, wave);
        cfg_write(swfs_pkg::CFG_START_LOW, slo);
        cfg_write(swfs_pkg::CFG_START_HIGH, {56'h0, shi});
        cfg_write(swfs_pkg::CFG_FINISH_LOW, flo);
        cfg_write(swfs_pkg::CFG_FINISH_HIGH, {48'h0, fhi});
        cfg_write(swfs_pkg::CFG_PROTOCOL_CODES, {24'h0, codes});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_settings();
        logic [7:0] rdy;
        logic [7:0] dat;
        rdy = 8'($urandom_range(0, 255));
        dat = ($urandom_range(0, 9) == 0) ? rdy : 8'($urandom_range(0, 255));
        load_settings(16'($urandom_range(0, 65535)), {$urandom, $urandom},
                      {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                      {$urandom, $urandom}, 16'($urandom_range(0, 65535)),
                      {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), dat, rdy});
    endtask

    // data command, then bytes until the frame closes; sample writes mixed in
    task automatic run_frame();
        send_spi(lane(codes_m, CODE_DATA_CMD), pick_fill());
        while (xmit_m) begin
            if ($urandom_range(0, 99) < 6)
                send_sample(9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
            else
                send_spi(8'($urandom_range(0, 255)), pick_fill());
        end
    endtask

    // all codes zero after reset: ready and data command collide
    task automatic test_reset_defaults();
        send_spi(8'h00, 10'd0);
        send_spi(8'h00, 10'd512);
        send_spi(8'hFF, 10'd511);
        send_sample(9'd0, 16'h1234);
    endtask

    // every store entry written before any frame can read it
    task automatic test_fill_store();
        int i;
        for (i = 0; i < DEPTH; i++) begin
            if (i == 0) send_sample(9'(i), 16'hFFFF);
            else if (i == 1) send_sample(9'(i), 16'h0000);
            else send_sample(9'(i), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_commands();
        load_settings(16'hA55A, 64'h0123_4567_89AB_CDEF, 64'h1122_3344_5566_7788,
                      8'h99, 64'h8877_6655_4433_2211, 16'hBEEF, 40'h3C_C3_96_D4_4D);
        send_spi(8'h4D, 10'd0);
        send_spi(8'h4D, 10'd511);
        send_spi(8'h4D, 10'd512);
        send_spi(8'h00, 10'd5);
        send_spi(8'hFF, 10'd512);
        send_sample(9'd511, 16'hFFFF);
        send_spi(8'h4D, 10'd256);
        // ready and data command equal: decoded as ready
        load_settings(16'h0000, '0, '0, 8'h00, '0, 16'h0000, 40'h11_22_33_77_77);
        send_spi(8'h77, 10'd100);
        send_spi(8'h77, 10'd512);
        send_spi(8'h78, 10'd0);
    endtask

    // one whole frame with all-ones ids, waveform info and marker registers
    task automatic test_frame_extremes();
        load_settings(16'hFFFF, '1, '1, 8'hFF, '1, 16'hFFFF, 40'hFF_00_FF_FF_00);
        run_frame();
        send_spi(8'h00, 10'd512);
    endtask

    task automatic test_random_traffic(input int n_req);
        int k;
        int pick;
        for (k = 0; k < n_req; k++) begin
            if (k % 300 == 0) random_settings();
            calm = (k >= n_req - n_req / 4);
            if (!calm && $urandom_range(0, 199) == 0) wait_results_done();
            pick = $urandom_range(0, 99);
            if (xmit_m) begin
                if (pick < 8)
                    send_sample(9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
                else
                    send_spi(8'($urandom_range(0, 255)), pick_fill());
            end else if (pick < 35) begin
                send_spi(lane(codes_m, CODE_READY_CMD), pick_fill());
            end else if (pick < 55) begin
                send_spi(8'($urandom_range(0, 255)), pick_fill());
            end else if (pick < 70) begin
                send_sample(9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
            end else begin
                send_spi(lane(codes_m, CODE_DATA_CMD), pick_fill());
            end
        end
    endtask

    // reply side stalls in bursts
    initial begin : sink_stalls
        int n;
        int k;
        k = 0;
        forever begin
            @(negedge clk);
            if (k % 64 == 0) stall_pct = idle_pct();
            k++;
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // compare each accepted reply with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (tx_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected reply tx=%h end=%b", $realtime, out_tx, out_end);
            end else begin
                chk_want = tx_due.pop_front();
                if (out_tx !== chk_want.tx || out_end !== chk_want.last) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: reply mismatch: expected tx=%h end=%b, got tx=%h end=%b",
                                 $realtime, chk_want.tx, chk_want.last, out_tx, out_end);
                end
            end
        end
    end

    // ends the run when no request moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_fill_store();
        test_commands();
        test_frame_extremes();
        test_random_traffic(80);
        wait_results_done();
        repeat (LATENCY + 4) @(posedge clk);
        if (tx_due.size() != 0) begin
            err_cnt += tx_due.size();
            $display("%0d predicted replies never arrived", tx_due.size());
        end
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
